// ===== design/chs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chs_pkg - shared types and constants for the cosine hemisphere sampler
// Word formats, fixed-point constants, pipeline depths and the reciprocal
// constants for the sine and cosine series.
// ----------------------------------------------------------------------------
package chs_pkg;

	localparam int COORD_FRAC_BITS = 14;
	localparam int RAND_BITS       = 16;
	localparam int LOCAL_FRAC      = 30;

	localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
	localparam logic [30:0] ONE_Q30     = 31'h4000_0000;

	localparam int ISQRT_STEPS = 32;
	localparam int DIV_STEPS   = 16;
	localparam int SINCOS_LAT  = 16;

	localparam int SIN_STEPS = 5;
	localparam int COS_STEPS = 6;

	// floor(p / k) = (p * magic) >> shift, exact for p below 2^30
	localparam int SIN_SHIFT [SIN_STEPS] = '{37, 37, 36, 35, 33};
	localparam logic [31:0] SIN_MAGIC [SIN_STEPS] = '{
		32'(((64'd1 << 37) + 64'd109) / 64'd110),
		32'(((64'd1 << 37) + 64'd71) / 64'd72),
		32'(((64'd1 << 36) + 64'd41) / 64'd42),
		32'(((64'd1 << 35) + 64'd19) / 64'd20),
		32'(((64'd1 << 33) + 64'd5) / 64'd6)
	};

	localparam int COS_SHIFT [COS_STEPS] = '{38, 37, 36, 35, 34, 31};
	localparam logic [31:0] COS_MAGIC [COS_STEPS] = '{
		32'(((64'd1 << 38) + 64'd131) / 64'd132),
		32'(((64'd1 << 37) + 64'd89) / 64'd90),
		32'(((64'd1 << 36) + 64'd55) / 64'd56),
		32'(((64'd1 << 35) + 64'd29) / 64'd30),
		32'(((64'd1 << 34) + 64'd11) / 64'd12),
		32'(((64'd1 << 31) + 64'd1) / 64'd2)
	};

	typedef struct packed {
		logic signed [15:0] normal_x;
		logic signed [15:0] normal_y;
		logic signed [15:0] normal_z;
		logic [15:0]        rand_angle;
		logic [15:0]        rand_height;
	} in_word_t;

	typedef struct packed {
		logic signed [15:0] dir_x;
		logic signed [15:0] dir_y;
		logic signed [15:0] dir_z;
		logic               degenerate;
	} out_word_t;

endpackage

// ===== design/chs_isqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chs_isqrt - pipelined integer square root
// Floor square root of a 64-bit radicand, one root bit per register stage.
// ----------------------------------------------------------------------------
module chs_isqrt (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] radicand,
	output logic [31:0] root
);

	localparam int N = chs_pkg::ISQRT_STEPS;

	logic [63:0] rad_s  [N];
	logic [33:0] rem_s  [N];
	logic [31:0] root_s [N];

	logic [63:0] rad_p  [N];
	logic [33:0] rem_p  [N];
	logic [31:0] root_p [N];

	logic [63:0] rad_n  [N];
	logic [33:0] rem_n  [N];
	logic [31:0] root_n [N];

	always_comb begin
		logic [35:0] acc;
		logic [35:0] trial;
		rad_p[0]  = radicand;
		rem_p[0]  = '0;
		root_p[0] = '0;
		for (int i = 1; i < N; i++) begin
			rad_p[i]  = rad_s[i-1];
			rem_p[i]  = rem_s[i-1];
			root_p[i] = root_s[i-1];
		end
		for (int i = 0; i < N; i++) begin
			acc   = {rem_p[i], rad_p[i][63:62]};
			trial = {2'b00, root_p[i], 2'b01};
			rad_n[i] = rad_p[i] << 2;
			if (acc >= trial) begin
				rem_n[i]  = 34'(acc - trial);
				root_n[i] = {root_p[i][30:0], 1'b1};
			end else begin
				rem_n[i]  = acc[33:0];
				root_n[i] = {root_p[i][30:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < N; i++) begin
				rad_s[i]  <= rad_n[i];
				rem_s[i]  <= rem_n[i];
				root_s[i] <= root_n[i];
			end
		end
	end

	assign root = root_s[N-1];

endmodule

// ===== design/chs_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chs_div - pipelined tangent normalizing divider
// Rounded |t| * 2^30 / r, one quotient bit per register stage, sign restored
// at the output.
// ----------------------------------------------------------------------------
module chs_div (
	input  logic               clk,
	input  logic               en,
	input  logic signed [16:0] t,
	input  logic [31:0]        r,
	output logic signed [15:0] tn
);

	localparam int N = chs_pkg::DIV_STEPS;

	logic [31:0] rem_s [N];
	logic [15:0] low_s [N];
	logic [31:0] r_s   [N];
	logic [15:0] q_s   [N];
	logic        neg_s [N];

	logic [31:0] rem_p [N];
	logic [15:0] low_p [N];
	logic [31:0] r_p   [N];
	logic [15:0] q_p   [N];
	logic        neg_p [N];

	logic [31:0] rem_n [N];
	logic [15:0] q_n   [N];

	always_comb begin
		logic [16:0] mag;
		logic [46:0] num;
		logic [32:0] trial;
		mag = t[16] ? 17'(-t) : 17'(t);
		// rounding term r/2 joins the numerator before the long division
		num = (47'(mag[15:0]) << 30) + 47'(r[31:1]);
		rem_p[0] = 32'(num[46:16]);
		low_p[0] = num[15:0];
		r_p[0]   = r;
		q_p[0]   = '0;
		neg_p[0] = t[16];
		for (int i = 1; i < N; i++) begin
			rem_p[i] = rem_s[i-1];
			low_p[i] = low_s[i-1];
			r_p[i]   = r_s[i-1];
			q_p[i]   = q_s[i-1];
			neg_p[i] = neg_s[i-1];
		end
		for (int i = 0; i < N; i++) begin
			trial = {rem_p[i], low_p[i][15]};
			if (trial >= {1'b0, r_p[i]}) begin
				rem_n[i] = 32'(trial - {1'b0, r_p[i]});
				q_n[i]   = {q_p[i][14:0], 1'b1};
			end else begin
				rem_n[i] = trial[31:0];
				q_n[i]   = {q_p[i][14:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < N; i++) begin
				rem_s[i] <= rem_n[i];
				low_s[i] <= low_p[i] << 1;
				r_s[i]   <= r_p[i];
				q_s[i]   <= q_n[i];
				neg_s[i] <= neg_p[i];
			end
		end
	end

	assign tn = neg_s[N-1] ? 16'(-q_s[N-1]) : q_s[N-1];

endmodule

// ===== design/chs_sincos.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chs_sincos - pipelined sine and cosine of a turn fraction
// Octant folding, Q30 radians, Horner series with one multiply per stage,
// quadrant restore, in a 16-stage pipeline.
// ----------------------------------------------------------------------------
module chs_sincos (
	input  logic               clk,
	input  logic               en,
	input  logic [15:0]        angle,
	output logic signed [31:0] co,
	output logic signed [31:0] si
);

	localparam int NC = 2 * chs_pkg::COS_STEPS;
	localparam int NS = 2 * chs_pkg::SIN_STEPS;

	logic [1:0]  q_s    [1:15];
	logic        fold_s [1:15];
	logic [30:0] a_s1;
	logic [30:0] x_s    [2:13];
	logic [30:0] x2_s   [3:13];
	logic [30:0] hc_s   [NC];
	logic [30:0] hs_s   [NS];
	logic [30:0] sf_s14;
	logic [30:0] sf_s15;
	logic [31:0] co_s16;
	logic [31:0] si_s16;

	logic [29:0] a_in;
	logic        fold_in;

	logic [31:0] c_f;
	logic [31:0] s_f;
	logic [31:0] co_n;
	logic [31:0] si_n;

	function automatic logic [30:0] mul_q30(input logic [30:0] a, input logic [30:0] b);
		logic [61:0] p;
		p = 62'(a) * 62'(b);
		return 31'(p >> 30);
	endfunction

	function automatic logic [30:0] horner_sub(input logic [30:0] p,
			input logic [31:0] magic, input int sh);
		logic [62:0] m;
		m = 63'(p) * 63'(magic);
		return chs_pkg::ONE_Q30 - 31'(m >> sh);
	endfunction

	assign a_in    = {angle[13:0], 16'd0};
	assign fold_in = a_in > 30'h2000_0000;

	always_ff @(posedge clk) begin
		if (en) begin
			q_s[1]    <= angle[15:14];
			fold_s[1] <= fold_in;
			a_s1      <= fold_in ? 31'(chs_pkg::ONE_Q30 - {1'b0, a_in}) : {1'b0, a_in};
			for (int i = 2; i < 16; i++) begin
				q_s[i]    <= q_s[i-1];
				fold_s[i] <= fold_s[i-1];
			end

			x_s[2] <= mul_q30(a_s1, chs_pkg::HALF_PI_Q30);
			for (int i = 3; i < 14; i++) x_s[i] <= x_s[i-1];
			x2_s[3] <= mul_q30(x_s[2], x_s[2]);
			for (int i = 4; i < 14; i++) x2_s[i] <= x2_s[i-1];

			// first series step starts from one, so its product is x2 itself
			hc_s[0] <= x2_s[3];
			hs_s[0] <= x2_s[3];
			for (int j = 0; j < chs_pkg::COS_STEPS; j++) begin
				if (j > 0) hc_s[2*j] <= mul_q30(x2_s[3+2*j], hc_s[2*j-1]);
				hc_s[2*j+1] <= horner_sub(hc_s[2*j], chs_pkg::COS_MAGIC[j],
					chs_pkg::COS_SHIFT[j]);
			end
			for (int j = 0; j < chs_pkg::SIN_STEPS; j++) begin
				if (j > 0) hs_s[2*j] <= mul_q30(x2_s[3+2*j], hs_s[2*j-1]);
				hs_s[2*j+1] <= horner_sub(hs_s[2*j], chs_pkg::SIN_MAGIC[j],
					chs_pkg::SIN_SHIFT[j]);
			end
			sf_s14 <= mul_q30(x_s[13], hs_s[NS-1]);
			sf_s15 <= sf_s14;

			co_s16 <= co_n;
			si_s16 <= si_n;
		end
	end

	always_comb begin
		c_f = fold_s[15] ? {1'b0, sf_s15} : {1'b0, hc_s[NC-1]};
		s_f = fold_s[15] ? {1'b0, hc_s[NC-1]} : {1'b0, sf_s15};
		case (q_s[15])
			2'd0: begin co_n = c_f;      si_n = s_f;      end
			2'd1: begin co_n = 32'(-s_f); si_n = c_f;      end
			2'd2: begin co_n = 32'(-c_f); si_n = 32'(-s_f); end
			default: begin co_n = s_f;  si_n = 32'(-c_f); end
		endcase
	end

	assign co = co_s16;
	assign si = si_s16;

endmodule

// ===== design/cosine_hemisphere_sampler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cosine_hemisphere_sampler - cosine-weighted direction around a normal
// Builds a tangent frame from the normal and rotates a cosine-weighted local
// direction into it, with rounding and saturation to Q2.14.
// ----------------------------------------------------------------------------
// Takes one word per clock while in_ready is high and returns one word per
// input word, in order. The pipeline depth is set by the 32-stage square root
// of the tangent length followed by the 16-stage divider that normalizes the
// tangent. A two-entry output stage (output register plus skid) keeps in_ready
// high while a finished word waits for out_ready; in_ready drops only when
// both entries are full. A normal of all zeros gives a zero direction with
// degenerate set.
module cosine_hemisphere_sampler (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  chs_pkg::in_word_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output chs_pkg::out_word_t out_data
);

	localparam int S_R    = 2 + chs_pkg::ISQRT_STEPS;
	localparam int S_TN   = S_R + chs_pkg::DIV_STEPS + 1;
	localparam int S_ANG  = S_TN - chs_pkg::SINCOS_LAT;
	localparam int S_HGT  = S_TN - chs_pkg::ISQRT_STEPS;
	localparam int S_LAST = S_TN + 3;

	logic en;

	logic                v_s   [1:S_LAST];
	logic signed [15:0]  n_s   [1:S_LAST-1][3];
	logic signed [16:0]  t_s   [1:S_R][3];
	logic                deg_s [2:S_LAST];
	logic [31:0]         l2_s2;
	logic [15:0]         ang_s [1:S_ANG];
	logic [15:0]         hgt_s [1:S_HGT];

	logic signed [15:0]  tn_s  [S_TN:S_TN+2][3];
	logic signed [31:0]  pa_s52 [3];
	logic signed [31:0]  pb_s52 [3];
	logic signed [63:0]  cp_s52;
	logic signed [63:0]  sp_s52;
	logic [30:0]         sqz_s52;
	logic signed [31:0]  lx_s53;
	logic signed [31:0]  ly_s53;
	logic [30:0]         lz_s53;
	logic signed [19:0]  b_s53 [3];
	logic signed [63:0]  pt_s54 [3];
	logic signed [63:0]  pu_s54 [3];
	logic signed [63:0]  pn_s54 [3];

	logic                out_valid_q;
	logic                skid_valid_q;
	chs_pkg::out_word_t  out_q;
	chs_pkg::out_word_t  skid_q;
	chs_pkg::out_word_t  res;

	function automatic logic signed [63:0] round_shift(input logic signed [63:0] v,
			input int s);
		logic [63:0] mag;
		mag = v[63] ? 64'(-v) : 64'(v);
		mag = (mag + (64'd1 << (s - 1))) >> s;
		return v[63] ? 64'(-mag) : 64'(mag);
	endfunction

	// ---- tangent selection -------------------------------------------------

	logic signed [15:0] n_in [3];
	logic [15:0]        mag_in [3];
	logic signed [16:0] t_in [3];

	always_comb begin
		n_in[0] = in_data.normal_x;
		n_in[1] = in_data.normal_y;
		n_in[2] = in_data.normal_z;
		for (int i = 0; i < 3; i++) mag_in[i] = n_in[i][15] ? 16'(-n_in[i]) : n_in[i];
		// smallest magnitude, ties to the lower index
		if (mag_in[0] <= mag_in[1] && mag_in[0] <= mag_in[2]) begin
			t_in[0] = '0;
			t_in[1] = 17'sd0 - 17'(n_in[2]);
			t_in[2] = 17'(n_in[1]);
		end else if (mag_in[1] <= mag_in[2]) begin
			t_in[1] = '0;
			t_in[2] = 17'sd0 - 17'(n_in[0]);
			t_in[0] = 17'(n_in[2]);
		end else begin
			t_in[2] = '0;
			t_in[0] = 17'sd0 - 17'(n_in[1]);
			t_in[1] = 17'(n_in[0]);
		end
	end

	// ---- arithmetic units --------------------------------------------------

	logic [31:0]        r_w;
	logic [31:0]        sqz_w;
	logic [31:0]        sq1_w;
	logic signed [15:0] tn_w [3];
	logic signed [31:0] co_w;
	logic signed [31:0] si_w;
	logic [16:0]        hgt_rest;

	assign hgt_rest = 17'(1 << chs_pkg::RAND_BITS) - 17'(hgt_s[S_HGT]);

	chs_isqrt u_len_sqrt (
		.clk      (clk),
		.en       (en),
		.radicand ({l2_s2, 32'd0}),
		.root     (r_w)
	);

	chs_isqrt u_z_sqrt (
		.clk      (clk),
		.en       (en),
		.radicand (64'(hgt_s[S_HGT]) << (60 - chs_pkg::RAND_BITS)),
		.root     (sqz_w)
	);

	chs_isqrt u_r_sqrt (
		.clk      (clk),
		.en       (en),
		.radicand (64'(hgt_rest) << (60 - chs_pkg::RAND_BITS)),
		.root     (sq1_w)
	);

	for (genvar g = 0; g < 3; g++) begin : g_div
		chs_div u_div (
			.clk (clk),
			.en  (en),
			.t   (t_s[S_R][g]),
			.r   (r_w),
			.tn  (tn_w[g])
		);
	end

	chs_sincos u_sincos (
		.clk   (clk),
		.en    (en),
		.angle (ang_s[S_ANG]),
		.co    (co_w),
		.si    (si_w)
	);

	// ---- datapath registers ------------------------------------------------

	logic signed [63:0] sq1_x;
	logic signed [63:0] sum_w [3];

	assign sq1_x = 64'(sq1_w[30:0]);

	always_ff @(posedge clk) begin
		if (en) begin
			n_s[1] <= n_in;
			t_s[1] <= t_in;
			for (int i = 2; i < S_LAST; i++) n_s[i] <= n_s[i-1];
			for (int i = 2; i <= S_R; i++) t_s[i] <= t_s[i-1];
			l2_s2 <= 32'(34'(t_s[1][0] * t_s[1][0]) + 34'(t_s[1][1] * t_s[1][1])
				+ 34'(t_s[1][2] * t_s[1][2]));
			deg_s[2] <= (t_s[1][0] == '0) && (t_s[1][1] == '0) && (t_s[1][2] == '0);
			for (int i = 3; i <= S_LAST; i++) deg_s[i] <= deg_s[i-1];
			ang_s[1] <= in_data.rand_angle;
			for (int i = 2; i <= S_ANG; i++) ang_s[i] <= ang_s[i-1];
			hgt_s[1] <= in_data.rand_height;
			for (int i = 2; i <= S_HGT; i++) hgt_s[i] <= hgt_s[i-1];

			tn_s[S_TN]   <= tn_w;
			tn_s[S_TN+1] <= tn_s[S_TN];
			tn_s[S_TN+2] <= tn_s[S_TN+1];

			// bitangent = normal x tangent, as two product terms per axis
			pa_s52[0] <= n_s[S_TN][1] * tn_s[S_TN][2];
			pb_s52[0] <= n_s[S_TN][2] * tn_s[S_TN][1];
			pa_s52[1] <= n_s[S_TN][2] * tn_s[S_TN][0];
			pb_s52[1] <= n_s[S_TN][0] * tn_s[S_TN][2];
			pa_s52[2] <= n_s[S_TN][0] * tn_s[S_TN][1];
			pb_s52[2] <= n_s[S_TN][1] * tn_s[S_TN][0];
			cp_s52  <= 64'(co_w) * sq1_x;
			sp_s52  <= 64'(si_w) * sq1_x;
			sqz_s52 <= sqz_w[30:0];

			lx_s53 <= 32'(round_shift(cp_s52, chs_pkg::LOCAL_FRAC));
			ly_s53 <= 32'(round_shift(sp_s52, chs_pkg::LOCAL_FRAC));
			lz_s53 <= sqz_s52;
			for (int i = 0; i < 3; i++)
				b_s53[i] <= 20'(round_shift(64'(pa_s52[i]) - 64'(pb_s52[i]),
					chs_pkg::COORD_FRAC_BITS));

			for (int i = 0; i < 3; i++) begin
				pt_s54[i] <= 64'(lx_s53) * 64'(tn_s[S_TN+2][i]);
				pu_s54[i] <= 64'(ly_s53) * 64'(b_s53[i]);
				pn_s54[i] <= 64'(lz_s53) * 64'(n_s[S_LAST-1][i]);
			end
		end
	end

	// ---- final sum, rounding and saturation --------------------------------

	logic signed [15:0] dir_w [3];

	always_comb begin
		logic signed [63:0] rv;
		for (int i = 0; i < 3; i++) begin
			sum_w[i] = pt_s54[i] + pu_s54[i] + pn_s54[i];
			rv = round_shift(sum_w[i], chs_pkg::LOCAL_FRAC);
			if (rv > 64'sd32767) dir_w[i] = 16'sh7FFF;
			else if (rv < -64'sd32768) dir_w[i] = 16'sh8000;
			else dir_w[i] = rv[15:0];
			if (deg_s[S_LAST]) dir_w[i] = '0;
		end
		res.dir_x      = dir_w[0];
		res.dir_y      = dir_w[1];
		res.dir_z      = dir_w[2];
		res.degenerate = deg_s[S_LAST];
	end

	// ---- valid bits and output stage ---------------------------------------

	assign en = !skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= S_LAST; i++) v_s[i] <= 1'b0;
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (en) begin
				v_s[1] <= in_valid;
				for (int i = 2; i <= S_LAST; i++) v_s[i] <= v_s[i-1];
			end
			if (out_valid_q && !out_ready) begin
				if (en && v_s[S_LAST]) skid_valid_q <= 1'b1;
			end else if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= v_s[S_LAST];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_valid_q && !out_ready) begin
			if (en) skid_q <= res;
		end else if (skid_valid_q) begin
			out_q <= skid_q;
		end else begin
			out_q <= res;
		end
	end

	assign in_ready  = en;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
